// ===== src/qzef_pkg.sv =====
// ----------------------------------------------------------------------------
// qzef_pkg
// shared types and constants of the quiet zone edge finder
// ----------------------------------------------------------------------------
package qzef_pkg;

  localparam int SampleW = 8;
  localparam int PosW    = 12;
  localparam int RunW    = 10;
  localparam int CauseW  = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 12;

  localparam int ImageExtent = 4096;
  localparam int PosUpperInt = (ImageExtent - 1 > (1 << PosW) - 1) ?
                               (1 << PosW) - 1 : ImageExtent - 1;
  localparam logic [PosW-1:0] PosUpper = PosUpperInt[PosW-1:0];

  localparam logic [SampleW-1:0] BandMinInit = '1;
  localparam logic [RunW-1:0]    RunMax      = '1;

  localparam logic [CauseW-1:0] CauseWhiteRun = 2'd0;
  localparam logic [CauseW-1:0] CauseDistance = 2'd1;
  localparam logic [CauseW-1:0] CauseBoundary = 2'd2;

  localparam logic [CfgIdxW-1:0] RegEdgeLevel   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWhiteRunLen = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxDistance = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStartPos    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScanDir     = 3'd4;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               band_last;
    logic               scan_end;
    logic               new_search;
  } in_word_t;

  typedef struct packed {
    logic [SampleW-1:0] white_level;
    logic [RunW-1:0]    white_run_length;
    logic [PosW-1:0]    max_search_distance;
    logic [PosW-1:0]    start_position;
    logic               scan_direction;
  } cfg_t;

endpackage

// ===== src/quiet_zone_edge_finder_unit.sv =====
// ----------------------------------------------------------------------------
// quiet_zone_edge_finder_unit
// Scans outward from a start coordinate for the outer edge of a symbol.
// Input words carry one band sample each, with band_last marking the last
// sample of a position, scan_end marking the image boundary and new_search
// starting a fresh search at start_position. Words are taken on in_valid and
// in_ready; at most one result word leaves on out_valid and out_ready when a
// search ends: the last dark position with cause 0 on a long enough white
// run, or zero with cause 1 (distance limit) or 2 (image boundary).
// A word that ends a search passes the input register, then the result
// register, before its result is presented.
// Throughput: one word per cycle; the stage logic is one compare and counter
// step per word. When the receiver stalls with a result pending, words that
// cause no result still flow; a word that would end a search waits in the
// input register until the result register frees.
// Reset clears the search (idle), the result register and loads the register
// defaults. Registers are written through cfg_we, cfg_index and cfg_wdata.
// ----------------------------------------------------------------------------
module quiet_zone_edge_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sample,
  input  logic        in_band_last,
  input  logic        in_scan_end,
  input  logic        in_new_search,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_edge_position,
  output logic [1:0]  out_stop_cause
);
  import qzef_pkg::*;

  cfg_t     cfg;
  in_word_t in_word, word;
  logic     word_valid, word_take;

  assign in_word.sample     = in_sample;
  assign in_word.band_last  = in_band_last;
  assign in_word.scan_end   = in_scan_end;
  assign in_word.new_search = in_new_search;

  qzef_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  qzef_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take)
  );

  qzef_scan u_scan (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .word_valid        (word_valid),
    .word              (word),
    .word_take         (word_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_edge_position (out_edge_position),
    .out_stop_cause    (out_stop_cause)
  );

endmodule

// ===== src/qzef_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// qzef_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module qzef_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [qzef_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [qzef_pkg::CfgDatW-1:0]  cfg_wdata,
  output qzef_pkg::cfg_t                cfg
);
  import qzef_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_level         <= 8'd128;
      cfg_r.white_run_length    <= 10'd8;
      cfg_r.max_search_distance <= 12'd4095;
      cfg_r.start_position      <= '0;
      cfg_r.scan_direction      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegEdgeLevel:   cfg_r.white_level         <= cfg_wdata[SampleW-1:0];
        RegWhiteRunLen: cfg_r.white_run_length    <= cfg_wdata[RunW-1:0];
        RegMaxDistance: cfg_r.max_search_distance <= cfg_wdata[PosW-1:0];
        RegStartPos:    cfg_r.start_position      <= cfg_wdata[PosW-1:0];
        RegScanDir:     cfg_r.scan_direction      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/qzef_in_reg.sv =====
// ----------------------------------------------------------------------------
// qzef_in_reg
// input word register, refilled in the cycle the scan stage takes its word
// ----------------------------------------------------------------------------
module qzef_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qzef_pkg::in_word_t in_word,
  output logic               word_valid,
  output qzef_pkg::in_word_t word,
  input  logic               word_take
);
  import qzef_pkg::*;

  logic     vld_r;
  in_word_t word_r;

  assign in_ready = !vld_r || word_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

  assign word_valid = vld_r;
  assign word       = word_r;

endmodule

// ===== src/qzef_scan.sv =====
// ----------------------------------------------------------------------------
// qzef_scan
// band minimum, white run and stop checks, with the result register
// ----------------------------------------------------------------------------
module qzef_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qzef_pkg::cfg_t        cfg,
  input  logic                  word_valid,
  input  qzef_pkg::in_word_t    word,
  output logic                  word_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [11:0]           out_edge_position,
  output logic [1:0]            out_stop_cause
);
  import qzef_pkg::*;

  logic [SampleW-1:0] band_min_r, band_min_nxt;
  logic [PosW-1:0]    pos_r, pos_nxt;
  logic [RunW-1:0]    run_r, run_nxt;
  logic [PosW-1:0]    dark_r, dark_nxt;
  logic               srch_r, srch_nxt;

  logic               out_vld_r;
  logic [PosW-1:0]    out_pos_r, res_pos;
  logic [CauseW-1:0]  out_cause_r, res_cause;

  logic [SampleW-1:0] bm_eff, bm_new;
  logic [PosW-1:0]    pos_eff, dark_eff;
  logic [RunW-1:0]    run_eff, run_new;
  logic               srch_eff, white;
  logic [PosW:0]      span;
  logic               dist_over, at_bound, produce;

  always_comb begin
    bm_eff   = word.new_search ? BandMinInit : band_min_r;
    pos_eff  = word.new_search ? cfg.start_position : pos_r;
    run_eff  = word.new_search ? '0 : run_r;
    dark_eff = word.new_search ? '0 : dark_r;
    srch_eff = word.new_search || srch_r;

    bm_new  = (word.sample < bm_eff) ? word.sample : bm_eff;
    white   = (bm_new >= cfg.white_level);
    run_new = white ? ((run_eff != RunMax) ? run_eff + 1'b1 : run_eff) : '0;

    if (cfg.scan_direction) begin
      span     = {1'b0, pos_eff} - {1'b0, cfg.start_position};
      at_bound = (pos_eff >= PosUpper);
    end else begin
      span     = {1'b0, cfg.start_position} - {1'b0, pos_eff};
      at_bound = (pos_eff == '0);
    end
    dist_over = !span[PosW] && (span[PosW-1:0] > cfg.max_search_distance);

    band_min_nxt = bm_new;
    pos_nxt      = pos_eff;
    run_nxt      = run_eff;
    dark_nxt     = dark_eff;
    srch_nxt     = srch_eff;
    produce      = 1'b0;
    res_pos      = '0;
    res_cause    = CauseWhiteRun;

    if (!srch_eff) begin
      band_min_nxt = band_min_r;
    end else if (word.band_last) begin
      band_min_nxt = BandMinInit;
      run_nxt      = run_new;
      dark_nxt     = white ? dark_eff : pos_eff;
      if (run_new > cfg.white_run_length) begin
        produce   = 1'b1;
        res_pos   = white ? dark_eff : pos_eff;
        res_cause = CauseWhiteRun;
      end else if (dist_over) begin
        produce   = 1'b1;
        res_cause = CauseDistance;
      end else if (word.scan_end || at_bound) begin
        produce   = 1'b1;
        res_cause = CauseBoundary;
      end else if (cfg.scan_direction) begin
        pos_nxt = pos_eff + 1'b1;
      end else begin
        pos_nxt = pos_eff - 1'b1;
      end
      if (produce) begin
        srch_nxt = 1'b0;
      end
    end
  end

  assign word_take = word_valid && (!produce || !out_vld_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_min_r <= BandMinInit;
      pos_r      <= '0;
      run_r      <= '0;
      dark_r     <= '0;
      srch_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (word_take) begin
        band_min_r <= band_min_nxt;
        pos_r      <= pos_nxt;
        run_r      <= run_nxt;
        dark_r     <= dark_nxt;
        srch_r     <= srch_nxt;
      end
      if (word_take && produce) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_take && produce) begin
      out_pos_r   <= res_pos;
      out_cause_r <= res_cause;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_edge_position = out_pos_r;
  assign out_stop_cause    = out_cause_r;

endmodule

// ===== bench/tb_quiet_zone_edge_finder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quiet_zone_edge_finder_unit
// Self-checking bench for the quiet zone edge finder. A scoreboard class
// tracks the search state and the registers, predicts the result word of
// every input word that ends a search, and compares each result word field
// by field. Stimulus is a directed pass over the boundary, distance and
// white run cases, then well-formed band scans with random content, some
// noise words, a long saturating white run, and random idling on both sides.
// ----------------------------------------------------------------------------

class edge_scoreboard;
  logic [7:0]  white_level;
  logic [9:0]  run_len;
  logic [11:0] max_dist;
  logic [11:0] start_pos;
  logic        scan_dir;

  logic [7:0]  band_min;
  logic [11:0] scan_pos;
  logic [9:0]  run_count;
  logic [11:0] dark_pos;
  bit          searching;

  logic [11:0] edge_pos_q[$];
  logic [1:0]  cause_q[$];
  int          busy_words;
  int          errors;

  function new();
    white_level = 8'd128;
    run_len     = 10'd8;
    max_dist    = 12'd4095;
    start_pos   = 12'd0;
    scan_dir    = 1'b0;
    band_min    = 8'hff;
    scan_pos    = '0;
    run_count   = '0;
    dark_pos    = '0;
    searching   = 0;
    busy_words  = 0;
    errors      = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [11:0] val);
    case (idx)
      qzef_pkg::RegEdgeLevel:   white_level = val[7:0];
      qzef_pkg::RegWhiteRunLen: run_len     = val[9:0];
      qzef_pkg::RegMaxDistance: max_dist    = val;
      qzef_pkg::RegStartPos:    start_pos   = val;
      qzef_pkg::RegScanDir:     scan_dir    = val[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return edge_pos_q.size();
  endfunction

  function void note_word(logic [7:0] sample, logic band_last, logic scan_end,
                          logic new_search);
    int          span;
    int          pos_top;
    bit          done;
    logic [11:0] res_pos;
    logic [1:0]  res_cause;
    done      = 0;
    res_pos   = '0;
    res_cause = qzef_pkg::CauseWhiteRun;
    pos_top   = (qzef_pkg::ImageExtent - 1 > 4095) ? 4095 : qzef_pkg::ImageExtent - 1;
    if (new_search) begin
      band_min  = 8'hff;
      run_count = '0;
      dark_pos  = '0;
      scan_pos  = start_pos;
      searching = 1;
    end
    if (searching) begin
      busy_words++;
      if (sample < band_min) band_min = sample;
      if (band_last) begin
        if (band_min >= white_level) begin
          if (run_count != 10'h3ff) run_count = run_count + 10'd1;
        end else begin
          dark_pos  = scan_pos;
          run_count = '0;
        end
        band_min = 8'hff;
        if (scan_dir) span = int'(scan_pos) - int'(start_pos);
        else span = int'(start_pos) - int'(scan_pos);
        if (run_count > run_len) begin
          done    = 1;
          res_pos = dark_pos;
        end else if (span > int'(max_dist)) begin
          done      = 1;
          res_cause = qzef_pkg::CauseDistance;
        end else if (scan_end || (scan_dir && int'(scan_pos) >= pos_top) ||
                     (!scan_dir && scan_pos == 12'd0)) begin
          done      = 1;
          res_cause = qzef_pkg::CauseBoundary;
        end else if (scan_dir) begin
          scan_pos = scan_pos + 12'd1;
        end else begin
          scan_pos = scan_pos - 12'd1;
        end
      end
    end
    if (done) begin
      searching = 0;
      band_min  = 8'hff;
      edge_pos_q.push_back(res_pos);
      cause_q.push_back(res_cause);
    end
  endfunction

  function void report(string what, int want, int got);
    if (errors < 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
    errors++;
  endfunction

  function void check_result(logic [11:0] edge_pos, logic [1:0] cause);
    logic [11:0] want_pos;
    logic [1:0]  want_cause;
    if (edge_pos_q.size() == 0) begin
      report("unexpected result word, edge_position", -1, edge_pos);
    end else begin
      want_pos   = edge_pos_q.pop_front();
      want_cause = cause_q.pop_front();
      if (edge_pos !== want_pos) report("edge_position", want_pos, edge_pos);
      if (cause !== want_cause) report("stop_cause", want_cause, cause);
    end
  endfunction
endclass

module tb_quiet_zone_edge_finder_unit;
  import qzef_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_sample = '0;
  logic        in_band_last = 1'b0;
  logic        in_scan_end = 1'b0;
  logic        in_new_search = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_edge_position;
  logic [1:0]  out_stop_cause;

  edge_scoreboard sb;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int stall_cycles = 0;

  quiet_zone_edge_finder_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_band_last      (in_band_last),
    .in_scan_end       (in_scan_end),
    .in_new_search     (in_new_search),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_edge_position (out_edge_position),
    .out_stop_cause    (out_stop_cause)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_edge_position, out_stop_cause);
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("tb_quiet_zone_edge_finder_unit: done, errors");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] s, input logic bl, input logic se,
                           input logic ns);
    logic took;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_band_last  <= bl;
    in_scan_end   <= se;
    in_new_search <= ns;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      if (took) sb.note_word(s, bl, se, ns);
      @(posedge clk);
    end
  endtask

  // pause the sender until every result word is back, then let the pipe empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_config(input int el, input int rl, input int md, input int sp,
                              input int sd);
    // junk in the unused upper bits now and then
    int junk;
    junk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0;
    write_reg(RegEdgeLevel, 12'(el) | (12'(junk) & 12'hf00));
    write_reg(RegWhiteRunLen, 12'(rl) | (12'(junk) & 12'hc00));
    write_reg(RegMaxDistance, 12'(md));
    write_reg(RegStartPos, 12'(sp));
    write_reg(RegScanDir, 12'(sd) | (12'(junk) & 12'hffe));
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int el;
    int rl;
    int md;
    int sp;
    case ($urandom_range(0, 5))
      0:       el = 0;
      1:       el = 255;
      default: el = $urandom_range(1, 254);
    endcase
    case ($urandom_range(0, 7))
      0:       rl = 0;
      1:       rl = 1023;
      default: rl = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 5))
      0:       md = 0;
      1:       md = 4095;
      2:       md = $urandom_range(0, 4095);
      default: md = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 5))
      0:       sp = 0;
      1:       sp = 4095;
      2:       sp = $urandom_range(0, 30);
      3:       sp = 4095 - $urandom_range(0, 30);
      default: sp = $urandom_range(0, 4095);
    endcase
    apply_config(el, rl, md, sp, $urandom_range(0, 1));
  endtask

  task automatic send_noise(input int n);
    repeat (n) begin
      send_word($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 3) == 0,
                $urandom_range(0, 7) == 0);
    end
  endtask

  // well-formed bands: one dark sample below the level makes a dark position
  task automatic scan_bands(input bit fresh, input int max_bands, input int dark_pct);
    int   nb;
    int   i;
    int   len;
    int   el;
    int   dark_at;
    bit   dark;
    bit   first;
    bit   se;
    logic [7:0] s;
    first = fresh;
    for (nb = 0; nb < max_bands; nb++) begin
      if (!first && !sb.searching) break;
      el      = sb.white_level;
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      dark    = (el != 0) && ($urandom_range(0, 99) < dark_pct);
      dark_at = $urandom_range(0, len - 1);
      se      = ($urandom_range(0, 39) == 0);
      for (i = 0; i < len; i++) begin
        if (dark && i == dark_at) s = $urandom_range(0, el - 1);
        else if (dark) s = $urandom_range(0, 255);
        else s = $urandom_range(el, 255);
        send_word(s, i == len - 1, (i == len - 1) ? se : ($urandom_range(0, 15) == 0),
                  first);
        first = 0;
      end
    end
  endtask

  // run count must stick at its top value, seen once the run length drops
  task automatic long_white_run();
    int i;
    drain_results();
    apply_config(100, 1023, 4095, 4095, 0);
    send_word(8'd10, 1'b1, 1'b0, 1'b1);
    for (i = 0; i < 1100; i++) send_word($urandom_range(100, 255), 1'b1, 1'b0, 1'b0);
    drain_results();
    apply_config(100, 5, 4095, 4095, 0);
    send_word(8'd255, 1'b1, 1'b0, 1'b0);
  endtask

  initial begin
    int phase;
    int set_n;
    int goal;
    int dark_pct;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: ignored while idle, then zero boundary going down
    send_word(8'd0, 1'b1, 1'b0, 1'b0);
    send_word(8'd200, 1'b1, 1'b0, 1'b1);
    drain_results();
    apply_config(100, 0, 4095, 10, 1);
    send_word(8'd0, 1'b0, 1'b0, 1'b1);
    send_word(8'd255, 1'b1, 1'b0, 1'b0);
    send_word(8'd255, 1'b1, 1'b0, 1'b0);
    // run found with no dark position
    send_word(8'd255, 1'b1, 1'b0, 1'b1);
    drain_results();
    apply_config(100, 3, 0, 4094, 1);
    send_word(8'd50, 1'b1, 1'b0, 1'b1);
    send_word(8'd50, 1'b1, 1'b0, 1'b0);
    drain_results();
    apply_config(100, 3, 4095, 4094, 1);
    send_word(8'd50, 1'b1, 1'b0, 1'b1);
    send_word(8'd50, 1'b1, 1'b0, 1'b0);
    send_word(8'd50, 1'b1, 1'b1, 1'b1);
    send_word(8'd50, 1'b0, 1'b1, 1'b1);
    send_word(8'd200, 1'b1, 1'b0, 1'b0);
    // restart in the middle of a search
    send_word(8'd255, 1'b1, 1'b0, 1'b1);
    drain_results();
    apply_config(100, 0, 0, 5, 0);
    send_word(8'd200, 1'b1, 1'b0, 1'b1);
    drain_results();
    apply_config(100, 3, 0, 5, 0);
    send_word(8'd50, 1'b1, 1'b0, 1'b1);
    send_word(8'd50, 1'b1, 1'b1, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 6;
          recv_gap_pct = 81;
        end
        1: begin
          send_gap_pct = 81;
          recv_gap_pct = 6;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      if (phase == 2) long_white_run();
      for (set_n = 0; set_n < 5; set_n++) begin
        drain_results();
        random_config();
        goal = sb.busy_words + 60;
        while (sb.busy_words < goal) begin
          if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 4));
          case ($urandom_range(0, 2))
            0:       dark_pct = 10;
            1:       dark_pct = 30;
            default: dark_pct = 60;
          endcase
          scan_bands(!(sb.searching && $urandom_range(0, 1) == 1), $urandom_range(3, 40),
                     dark_pct);
        end
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_quiet_zone_edge_finder_unit: done, clean");
    end else begin
      $display("tb_quiet_zone_edge_finder_unit: done, errors");
    end
    $finish;
  end

endmodule
